[src/assert_macros.svh]
// Assertion macros used by the checker file of this project.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// The consequent must hold in the same cycle as the antecedent.
`define ASSERT_IMPLIES(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

[src/lpr_pkg.sv]
// Package with the shared types and constants of the LRU page replacement block.
`timescale 1ns / 1ps

package lpr_pkg;

  localparam int unsigned PAGE_W      = 16;
  localparam int unsigned IDX_OUT_W   = 4;
  localparam int unsigned STAMP_W     = 32;
  localparam int unsigned COUNT_W     = 32;
  localparam int unsigned CFG_W       = 5;
  localparam int unsigned FIELD_MAX   = 16;
  localparam int unsigned APB_DATA_W  = 32;
  localparam int unsigned APB_ADDR_W  = 3;

  localparam logic [STAMP_W-1:0] STAMP_MAX = '1;
  localparam logic [COUNT_W-1:0] COUNT_MAX = '1;

  localparam logic [CFG_W-1:0] FRAMES_IN_USE_RESET = 5'd4;

  typedef enum logic [0:0] {
    REG_FRAMES_IN_USE = 1'b0,
    REG_NONE          = 1'b1
  } reg_idx_t;

  typedef enum logic [2:0] {
    ST_IDLE  = 3'b001,
    ST_SCAN  = 3'b010,
    ST_WRITE = 3'b100
  } state_t;

endpackage

[src/lpr_page_if.sv]
// Channel interfaces for page references and replacement results.
`timescale 1ns / 1ps

interface lpr_page_if;
  logic                        valid;
  logic                        ready;
  logic [lpr_pkg::PAGE_W-1:0]  page_number;

  modport source (output valid, output page_number, input ready);
  modport sink (input valid, input page_number, output ready);
endinterface

interface lpr_result_if;
  logic                          valid;
  logic                          ready;
  logic                          hit;
  logic [lpr_pkg::IDX_OUT_W-1:0] frame_index;
  logic                          evicted_valid;
  logic [lpr_pkg::PAGE_W-1:0]    evicted_page;
  logic [lpr_pkg::COUNT_W-1:0]   fault_count;
  logic                          stamp_saturated;

  modport source (output valid, output hit, output frame_index, output evicted_valid,
                  output evicted_page, output fault_count, output stamp_saturated,
                  input ready);
  modport sink (input valid, input hit, input frame_index, input evicted_valid,
                input evicted_page, input fault_count, input stamp_saturated,
                output ready);
endinterface

[src/lru_page_replacement.sv]
// Top level of the LRU page replacement block with a time-stamped frame memory.
// Each reference scans the active frames through a registered memory port,
// one frame per cycle, then writes the chosen frame back once the result
// register is free; a new reference is accepted only when the block is idle again.
// Reset clears the frame valid bits and counters and loads the configuration
// register with its reset value at once; no clearing pass is needed.
`timescale 1ns / 1ps

module lru_page_replacement #(
  parameter int unsigned FRAMES    = 16,
  parameter int unsigned PAGE_BITS = 16
) (
  input  logic                               clk,
  input  logic                               rst,
  lpr_page_if.sink                           req,
  lpr_result_if.source                       rsp,
  input  logic                               psel,
  input  logic                               penable,
  input  logic                               pwrite,
  input  logic [lpr_pkg::APB_ADDR_W-1:0]     paddr,
  input  logic [lpr_pkg::APB_DATA_W-1:0]     pwdata,
  output logic [lpr_pkg::APB_DATA_W-1:0]     prdata,
  output logic                               pready
);

  localparam int unsigned IDX_W  = $clog2(FRAMES);
  localparam int unsigned NMAX   = (FRAMES < lpr_pkg::FIELD_MAX) ? FRAMES : lpr_pkg::FIELD_MAX;
  localparam int unsigned CNT_W  = $clog2(NMAX + 1);
  localparam int unsigned WORD_W = PAGE_BITS + lpr_pkg::STAMP_W;

  lpr_pkg::state_t state, state_next;

  logic [lpr_pkg::CFG_W-1:0]   frames_in_use;
  logic [CNT_W-1:0]            active_n;
  logic [CNT_W-1:0]            cnt;
  logic                        issue;

  logic [WORD_W-1:0]           mem [FRAMES];
  logic [FRAMES-1:0]           ent_valid;
  logic [WORD_W-1:0]           rd_word;
  logic                        rd_ent_valid;
  logic                        rd_vld;
  logic                        rd_last;
  logic [IDX_W-1:0]            rd_idx;

  logic [PAGE_BITS-1:0]        page;
  logic [PAGE_BITS-1:0]        rd_page;
  logic [lpr_pkg::STAMP_W-1:0] rd_stamp;

  logic                        found;
  logic [IDX_W-1:0]            hit_idx;
  logic [IDX_W-1:0]            victim;
  logic [lpr_pkg::STAMP_W-1:0] min_stamp;
  logic [PAGE_BITS-1:0]        victim_page;

  logic [lpr_pkg::STAMP_W-1:0] time_now, time_next;
  logic [lpr_pkg::COUNT_W-1:0] faults, faults_next;
  logic [IDX_W-1:0]            slot;
  logic                        ev_valid;
  logic                        out_free;
  logic                        commit;
  logic                        cfg_write;
  lpr_pkg::reg_idx_t           reg_sel;

  // Configuration port.
  assign pready    = 1'b1;
  assign reg_sel   = lpr_pkg::reg_idx_t'(paddr[2]);
  assign cfg_write = psel && penable && pwrite;

  always_comb begin
    case (reg_sel)
      lpr_pkg::REG_FRAMES_IN_USE: prdata = lpr_pkg::APB_DATA_W'(frames_in_use);
      default:                    prdata = '0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      frames_in_use <= lpr_pkg::FRAMES_IN_USE_RESET;
    end else if (cfg_write && reg_sel == lpr_pkg::REG_FRAMES_IN_USE) begin
      frames_in_use <= pwdata[lpr_pkg::CFG_W-1:0];
    end
  end

  always_comb begin
    if (frames_in_use == '0) begin
      active_n = CNT_W'(1);
    end else if (32'(frames_in_use) > NMAX) begin
      active_n = CNT_W'(NMAX);
    end else begin
      active_n = CNT_W'(frames_in_use);
    end
  end

  // Sequencer.
  assign req.ready = (state == lpr_pkg::ST_IDLE);
  assign issue     = (state == lpr_pkg::ST_SCAN) && (cnt != active_n);
  assign out_free  = !rsp.valid || rsp.ready;
  assign commit    = (state == lpr_pkg::ST_WRITE) && out_free;

  always_comb begin
    state_next = state;
    case (state)
      lpr_pkg::ST_IDLE:  if (req.valid) state_next = lpr_pkg::ST_SCAN;
      lpr_pkg::ST_SCAN:  if (rd_vld && rd_last) state_next = lpr_pkg::ST_WRITE;
      lpr_pkg::ST_WRITE: if (out_free) state_next = lpr_pkg::ST_IDLE;
      default:           state_next = lpr_pkg::ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state  <= lpr_pkg::ST_IDLE;
      cnt    <= '0;
      rd_vld <= 1'b0;
    end else begin
      state  <= state_next;
      rd_vld <= issue;
      if (state == lpr_pkg::ST_IDLE) begin
        cnt <= '0;
      end else if (issue) begin
        cnt <= cnt + CNT_W'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (req.valid && req.ready) begin
      page <= PAGE_BITS'(req.page_number);
    end
    if (issue) begin
      rd_idx  <= IDX_W'(cnt);
      rd_last <= (cnt == active_n - CNT_W'(1));
    end
  end

  // Frame memory, one read or one write per cycle.
  always_ff @(posedge clk) begin
    if (issue) begin
      rd_word <= mem[IDX_W'(cnt)];
    end
    if (commit) begin
      mem[slot] <= {page, time_next};
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      ent_valid <= '0;
    end else if (commit) begin
      ent_valid[slot] <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (issue) begin
      rd_ent_valid <= ent_valid[IDX_W'(cnt)];
    end
  end

  assign rd_page  = rd_ent_valid ? rd_word[WORD_W-1:lpr_pkg::STAMP_W] : '0;
  assign rd_stamp = rd_ent_valid ? rd_word[lpr_pkg::STAMP_W-1:0] : '0;

  // Hit search and minimum-stamp search, one frame per cycle.
  always_ff @(posedge clk) begin
    if (rst) begin
      found <= 1'b0;
    end else if (req.valid && req.ready) begin
      found <= 1'b0;
    end else if (rd_vld && !found && rd_stamp != '0 && rd_page == page) begin
      found <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (rd_vld) begin
      if (!found && rd_stamp != '0 && rd_page == page) begin
        hit_idx <= rd_idx;
      end
      if (rd_idx == '0 || rd_stamp < min_stamp) begin
        min_stamp   <= rd_stamp;
        victim      <= rd_idx;
        victim_page <= rd_page;
      end
    end
  end

  // Write-back and result.
  assign slot      = found ? hit_idx : victim;
  assign ev_valid  = !found && (min_stamp != '0);
  assign time_next = (time_now == lpr_pkg::STAMP_MAX) ? time_now
                                                      : time_now + lpr_pkg::STAMP_W'(1);
  assign faults_next = (found || faults == lpr_pkg::COUNT_MAX) ? faults
                                                               : faults + lpr_pkg::COUNT_W'(1);

  always_ff @(posedge clk) begin
    if (rst) begin
      time_now  <= '0;
      faults    <= '0;
      rsp.valid <= 1'b0;
    end else begin
      if (commit) begin
        time_now  <= time_next;
        faults    <= faults_next;
        rsp.valid <= 1'b1;
      end else if (rsp.ready) begin
        rsp.valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (commit) begin
      rsp.hit             <= found;
      rsp.frame_index     <= lpr_pkg::IDX_OUT_W'(slot);
      rsp.evicted_valid   <= ev_valid;
      rsp.evicted_page    <= ev_valid ? lpr_pkg::PAGE_W'(victim_page) : '0;
      rsp.fault_count     <= faults_next;
      rsp.stamp_saturated <= (time_next == lpr_pkg::STAMP_MAX);
    end
  end

endmodule

[src/lpr_checker.sv]
// Port-level checker for the LRU page replacement block and its bind.
`timescale 1ns / 1ps
`include "assert_macros.svh"

module lpr_checker (
  input logic                        clk,
  input logic                        rst,
  input logic                        rsp_valid,
  input logic                        rsp_ready,
  input logic                        rsp_hit,
  input logic                        rsp_evicted_valid,
  input logic [lpr_pkg::PAGE_W-1:0]  rsp_evicted_page,
  input logic [lpr_pkg::COUNT_W-1:0] rsp_fault_count
);

  `ASSERT_NEXT(a_rsp_hold, clk, rst, rsp_valid && !rsp_ready, rsp_valid && $stable(rsp_fault_count) && $stable(rsp_evicted_page), "Result word changed while stalled.")
  `ASSERT_IMPLIES(a_hit_no_evict, clk, rst, rsp_valid && rsp_hit, !rsp_evicted_valid, "A hit reported an eviction.")
  `ASSERT_IMPLIES(a_evict_page_zero, clk, rst, rsp_valid && !rsp_evicted_valid, rsp_evicted_page == '0, "Evicted page is not zero without an eviction.")
  `ASSERT_IMPLIES(a_miss_counted, clk, rst, rsp_valid && !rsp_hit, rsp_fault_count != '0, "A page fault left the fault count at zero.")

endmodule

bind lru_page_replacement lpr_checker u_lpr_checker (
  .clk               (clk),
  .rst               (rst),
  .rsp_valid         (rsp.valid),
  .rsp_ready         (rsp.ready),
  .rsp_hit           (rsp.hit),
  .rsp_evicted_valid (rsp.evicted_valid),
  .rsp_evicted_page  (rsp.evicted_page),
  .rsp_fault_count   (rsp.fault_count)
);

[tb/lru_page_replacement_tb.sv]
// Self-checking testbench for the LRU page replacement block with its own replacement predictor.
`timescale 1ns / 1ps

module lru_page_replacement_tb;

  localparam int unsigned NUM_FRAMES   = 16;
  localparam int unsigned POOL_SIZE    = 20;
  localparam int unsigned PHASES       = 8;
  localparam int unsigned PHASE_ITEMS  = 188;
  localparam int unsigned CYCLE_LIMIT  = 600000;
  localparam int unsigned DRAIN_CYCLES = 40;
  localparam int unsigned REPORT_MAX   = 10;

  typedef struct packed {
    logic                          hit;
    logic [lpr_pkg::IDX_OUT_W-1:0] frame_index;
    logic                          evicted_valid;
    logic [lpr_pkg::PAGE_W-1:0]    evicted_page;
    logic [lpr_pkg::COUNT_W-1:0]   fault_count;
    logic                          stamp_saturated;
  } lru_word_t;

  // Tracks frame contents and time stamps and holds the words still to come.
  class lru_scoreboard;
    lru_word_t                   expected_q[$];
    logic [lpr_pkg::PAGE_W-1:0]  frame_page[NUM_FRAMES];
    logic [lpr_pkg::STAMP_W-1:0] frame_stamp[NUM_FRAMES];
    logic [lpr_pkg::STAMP_W-1:0] time_now;
    logic [lpr_pkg::COUNT_W-1:0] faults;
    logic [lpr_pkg::CFG_W-1:0]   frames_reg;
    int unsigned                 mismatches;

    function new();
      for (int i = 0; i < NUM_FRAMES; i++) begin
        frame_page[i]  = '0;
        frame_stamp[i] = '0;
      end
      time_now   = '0;
      faults     = '0;
      frames_reg = lpr_pkg::FRAMES_IN_USE_RESET;
      mismatches = 0;
    endfunction

    function void set_frames(logic [lpr_pkg::APB_DATA_W-1:0] value);
      frames_reg = value[lpr_pkg::CFG_W-1:0];
    endfunction

    function int unsigned pending();
      return expected_q.size();
    endfunction

    function logic [lpr_pkg::STAMP_W-1:0] advance_time();
      if (time_now != lpr_pkg::STAMP_MAX) time_now = time_now + 1;
      return time_now;
    endfunction

    function void note_page(logic [lpr_pkg::PAGE_W-1:0] page);
      int unsigned active;
      int unsigned slot;
      int unsigned victim;
      bit          found;
      lru_word_t   word;
      active = frames_reg;
      if (active < 1) active = 1;
      if (active > lpr_pkg::FIELD_MAX) active = lpr_pkg::FIELD_MAX;
      if (active > NUM_FRAMES) active = NUM_FRAMES;
      slot   = 0;
      victim = 0;
      found  = 1'b0;
      word   = '0;
      for (int unsigned i = 0; i < active; i++) begin
        if (!found && frame_stamp[i] != '0 && frame_page[i] == page) begin
          found = 1'b1;
          slot  = i;
        end
        if (frame_stamp[i] < frame_stamp[victim]) victim = i;
      end
      if (found) begin
        frame_stamp[slot] = advance_time();
      end else begin
        if (faults != lpr_pkg::COUNT_MAX) faults = faults + 1;
        slot = victim;
        if (frame_stamp[slot] != '0) begin
          word.evicted_valid = 1'b1;
          word.evicted_page  = frame_page[slot];
        end
        frame_page[slot]  = page;
        frame_stamp[slot] = advance_time();
      end
      word.hit             = found;
      word.frame_index     = slot[lpr_pkg::IDX_OUT_W-1:0];
      word.fault_count     = faults;
      word.stamp_saturated = (time_now == lpr_pkg::STAMP_MAX);
      expected_q.push_back(word);
    endfunction

    function void check_result(lru_word_t got);
      lru_word_t want;
      if (expected_q.size() == 0) begin
        mismatches++;
        if (mismatches <= REPORT_MAX)
          $display("%0t: result word with no reference outstanding", $realtime);
        return;
      end
      want = expected_q.pop_front();
      if (got !== want) begin
        mismatches++;
        if (mismatches <= REPORT_MAX)
          $display({"%0t: mismatch hit %b/%b frame %0d/%0d evicted %b/%b page %h/%h ",
                    "faults %0d/%0d saturated %b/%b (expected/actual)"},
                   $realtime, want.hit, got.hit, want.frame_index, got.frame_index,
                   want.evicted_valid, got.evicted_valid, want.evicted_page,
                   got.evicted_page, want.fault_count, got.fault_count,
                   want.stamp_saturated, got.stamp_saturated);
      end
    endfunction
  endclass

  logic                               clk;
  logic                               rst;
  logic                               psel;
  logic                               penable;
  logic                               pwrite;
  logic [lpr_pkg::APB_ADDR_W-1:0]     paddr;
  logic [lpr_pkg::APB_DATA_W-1:0]     pwdata;
  logic [lpr_pkg::APB_DATA_W-1:0]     prdata;
  logic                               pready;

  lpr_page_if   req_if();
  lpr_result_if rsp_if();

  lru_page_replacement DUT (
    .clk     (clk),
    .rst     (rst),
    .req     (req_if),
    .rsp     (rsp_if),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready)
  );

  lru_scoreboard              sb;
  int unsigned                idle_pct;
  int unsigned                stall_pct;
  int unsigned                cycle_count = 0;
  logic [lpr_pkg::PAGE_W-1:0] page_pool[POOL_SIZE];

  always begin
    clk = 1'b0;
    #10;
    clk = 1'b1;
    #10;
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("== FAIL ==");
      $finish;
    end
  end

  always @(negedge clk) begin
    rsp_if.ready <= ($urandom_range(0, 99) >= stall_pct);
  end

  always @(posedge clk) begin
    if (!rst) begin
      if (req_if.valid && req_if.ready) sb.note_page(req_if.page_number);
      if (rsp_if.valid && rsp_if.ready)
        sb.check_result('{hit: rsp_if.hit, frame_index: rsp_if.frame_index,
                          evicted_valid: rsp_if.evicted_valid,
                          evicted_page: rsp_if.evicted_page,
                          fault_count: rsp_if.fault_count,
                          stamp_saturated: rsp_if.stamp_saturated});
    end
  end

  task automatic send_page(input logic [lpr_pkg::PAGE_W-1:0] page);
    while ($urandom_range(0, 99) < idle_pct) begin
      req_if.valid <= 1'b0;
      @(negedge clk);
    end
    req_if.valid       <= 1'b1;
    req_if.page_number <= page;
    @(posedge clk);
    while (!req_if.ready) @(posedge clk);
    @(negedge clk);
  endtask

  task automatic wait_drained();
    while (sb.pending() != 0) @(posedge clk);
    @(negedge clk);
  endtask

  task automatic write_reg(input lpr_pkg::reg_idx_t idx,
                           input logic [lpr_pkg::APB_DATA_W-1:0] value);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {idx, 2'b00};
    pwdata  <= value;
    @(negedge clk);
    penable <= 1'b1;
    @(posedge clk);
    while (!pready) @(posedge clk);
    @(negedge clk);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    if (idx == lpr_pkg::REG_FRAMES_IN_USE) sb.set_frames(value);
  endtask

  function automatic logic [lpr_pkg::PAGE_W-1:0] pick_page(int unsigned span);
    int unsigned r;
    r = $urandom_range(0, 99);
    if (r < 75) return page_pool[$urandom_range(0, span)];
    if (r < 78) return ($urandom_range(0, 1) != 0) ? '1 : '0;
    return lpr_pkg::PAGE_W'($urandom);
  endfunction

  initial begin
    int unsigned                cfg_val;
    logic [lpr_pkg::PAGE_W-1:0] directed_a[9];
    logic [lpr_pkg::PAGE_W-1:0] directed_b[3];
    logic [lpr_pkg::PAGE_W-1:0] directed_c[6];
    sb                 = new();
    idle_pct           = 0;
    stall_pct          = 0;
    rst                = 1'b1;
    psel               = 1'b0;
    penable            = 1'b0;
    pwrite             = 1'b0;
    paddr              = '0;
    pwdata             = '0;
    req_if.valid       = 1'b0;
    req_if.page_number = '0;
    for (int i = 0; i < POOL_SIZE; i++) page_pool[i] = lpr_pkg::PAGE_W'($urandom);
    directed_a = '{16'h0000, 16'h0000, 16'hFFFF, 16'h5555, 16'hAAAA,
                   16'hFFFF, 16'h1234, 16'h0001, 16'h8000};
    directed_b = '{16'hAAAA, 16'h0000, 16'h7FFF};
    directed_c = '{16'hFFFF, 16'h1234, 16'h5555, 16'h0001, 16'hFEDC, 16'h0123};
    repeat (5) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);

    // Reset frame count first; page zero must miss while its frame is empty.
    foreach (directed_a[i]) send_page(directed_a[i]);
    req_if.valid <= 1'b0;
    wait_drained();
    write_reg(lpr_pkg::REG_NONE, 32'h0000_0001);
    send_page(16'h5555);
    req_if.valid <= 1'b0;
    wait_drained();
    // A count of zero acts as one frame.
    write_reg(lpr_pkg::REG_FRAMES_IN_USE, 32'h0000_0000);
    foreach (directed_b[i]) send_page(directed_b[i]);
    req_if.valid <= 1'b0;
    wait_drained();
    // An oversized count acts as all frames; the hidden frames come back.
    write_reg(lpr_pkg::REG_FRAMES_IN_USE, 32'hFFFF_FFFF);
    foreach (directed_c[i]) send_page(directed_c[i]);
    req_if.valid <= 1'b0;

    for (int unsigned phase = 0; phase < PHASES; phase++) begin
      case (phase % 4)
        0: begin
          idle_pct  = 0;
          stall_pct = 0;
        end
        1: begin
          idle_pct  = 53;
          stall_pct = 0;
        end
        2: begin
          idle_pct  = 0;
          stall_pct = 53;
        end
        default: begin
          idle_pct  = 28;
          stall_pct = 28;
        end
      endcase
      case (phase)
        0: cfg_val = 1;
        1: cfg_val = 16;
        2: cfg_val = 2;
        3: cfg_val = 31;
        4: cfg_val = 0;
        5: cfg_val = $urandom_range(3, 15);
        6: cfg_val = 8;
        default: cfg_val = 16;
      endcase
      wait_drained();
      write_reg(lpr_pkg::REG_FRAMES_IN_USE, ($urandom & ~32'h1F) | cfg_val);
      for (int unsigned k = 0; k < PHASE_ITEMS; k++)
        send_page(pick_page((cfg_val > 15 || cfg_val == 0) ? POOL_SIZE - 1 : cfg_val + 3));
      req_if.valid <= 1'b0;
    end

    stall_pct = 0;
    wait_drained();
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (sb.pending() != 0)
      $display("%0d expected result words never arrived", sb.pending());
    if (sb.mismatches == 0 && sb.pending() == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

endmodule
